[rtl/hois_pkg.sv]
package hois_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_PROC,
    S_TAIL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic proc;
    logic tail;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic count_zero;
    logic last;
    logic again;
    logic out_free;
  } sts_t;

endpackage

[rtl/half_open_interval_set.sv]
// Channel   Handshake                Payload
// input     in_valid / in_ready      action, range_start, range_end
// output    out_valid / out_ready    covered, status
//
// An item reads and processes each stored interval in turn, with an extra processing
// step when a removed range splits an interval or an added range lands ahead of a
// stored one; an empty range or the unused action skips the table walk.
// Reset empties the table at once; no clearing pass is needed.
// A result waits in the output register; the next item is not taken until the
// current one has been placed there.
module half_open_interval_set #(
  parameter int MAX_ENTRIES = 64,
  parameter int COORD_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] range_start,
  input  logic [31:0] range_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        covered,
  output logic [1:0]  status
);

  hois_pkg::cmd_t cmd;
  hois_pkg::sts_t sts;

  hois_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hois_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .action      (action),
    .range_start (range_start),
    .range_end   (range_end),
    .covered     (covered),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

[rtl/hois_ctrl.sv]
module hois_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hois_pkg::sts_t    sts,
  output hois_pkg::cmd_t    cmd
);

  hois_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hois_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hois_pkg::S_IDLE: begin
        if (in_valid) state_next = hois_pkg::S_CHECK;
      end
      hois_pkg::S_CHECK: begin
        priority if (sts.skip) state_next = hois_pkg::S_FINISH;
        else if (sts.count_zero) state_next = hois_pkg::S_TAIL;
        else state_next = hois_pkg::S_READ;
      end
      hois_pkg::S_READ: state_next = hois_pkg::S_PROC;
      hois_pkg::S_PROC: begin
        priority if (sts.again) state_next = hois_pkg::S_PROC;
        else if (sts.last) state_next = hois_pkg::S_TAIL;
        else state_next = hois_pkg::S_READ;
      end
      hois_pkg::S_TAIL: state_next = hois_pkg::S_FINISH;
      hois_pkg::S_FINISH: begin
        if (sts.out_free) state_next = hois_pkg::S_IDLE;
      end
      default: state_next = hois_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      hois_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      hois_pkg::S_READ:   cmd.rd = 1'b1;
      hois_pkg::S_PROC:   cmd.proc = 1'b1;
      hois_pkg::S_TAIL:   cmd.tail = 1'b1;
      hois_pkg::S_FINISH: cmd.finish = sts.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/hois_dp.sv]
module hois_dp #(
  parameter int MAX_ENTRIES = 64,
  parameter int COORD_BITS  = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     action,
  input  logic [31:0]    range_start,
  input  logic [31:0]    range_end,
  output logic           covered,
  output logic [1:0]     status,
  output logic           out_valid,
  input  logic           out_ready,
  input  hois_pkg::cmd_t cmd,
  output hois_pkg::sts_t sts
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int MW = $clog2(MAX_ENTRIES + 2);
  localparam int DEPTH = 2 ** (AW + 1);

  logic [2*COORD_BITS-1:0] mem [DEPTH];

  logic [COORD_BITS+31:0] ext_l, ext_r;
  logic [COORD_BITS-1:0]  l, r, ms, me, rs, re;
  logic [1:0]             act;
  logic                   bank, placed, sub, cov;
  logic [CW-1:0]          count, idx;
  logic [MW-1:0]          m;

  logic                   wr_en, again, set_placed, merge, sub_next;
  logic [COORD_BITS-1:0]  ws, we;

  assign ext_l = {{COORD_BITS{1'b0}}, range_start};
  assign ext_r = {{COORD_BITS{1'b0}}, range_end};

  always_comb begin
    wr_en      = 1'b0;
    again      = 1'b0;
    set_placed = 1'b0;
    merge      = 1'b0;
    sub_next   = 1'b0;
    ws         = rs;
    we         = re;
    if (cmd.proc) begin
      unique case (act)
        hois_pkg::ACT_ADD: begin
          priority if (re < l) begin
            wr_en = 1'b1;
          end else if (!placed && rs <= r) begin
            merge = 1'b1;
          end else if (!placed) begin
            wr_en      = 1'b1;
            ws         = ms;
            we         = me;
            set_placed = 1'b1;
            again      = 1'b1;
          end else begin
            wr_en = 1'b1;
          end
        end
        hois_pkg::ACT_REMOVE: begin
          priority if (!sub && rs < l) begin
            wr_en    = 1'b1;
            we       = (re < l) ? re : l;
            again    = (re > r);
            sub_next = (re > r);
          end else if (re > r) begin
            wr_en = 1'b1;
            ws    = (rs > r) ? rs : r;
          end else begin
            wr_en = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd.tail && act == hois_pkg::ACT_ADD && !placed) begin
      wr_en = 1'b1;
      ws    = ms;
      we    = me;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && m < MW'(MAX_ENTRIES)) begin
      mem[{~bank, m[AW-1:0]}] <= {ws, we};
    end
    if (cmd.rd) begin
      {rs, re} <= mem[{bank, idx[AW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= action;
      l      <= ext_l[COORD_BITS-1:0];
      r      <= ext_r[COORD_BITS-1:0];
      ms     <= ext_l[COORD_BITS-1:0];
      me     <= ext_r[COORD_BITS-1:0];
      placed <= 1'b0;
      sub    <= 1'b0;
      cov    <= 1'b0;
      idx    <= '0;
      m      <= '0;
    end else begin
      if (merge) begin
        if (rs < ms) ms <= rs;
        if (re > me) me <= re;
      end
      if (set_placed) placed <= 1'b1;
      if (cmd.proc) begin
        sub <= sub_next;
        if (act == hois_pkg::ACT_QUERY && rs <= l && re >= r) cov <= 1'b1;
        if (!again) idx <= idx + 1'b1;
      end
      if (wr_en && m <= MW'(MAX_ENTRIES)) m <= m + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (!(l >= r) && (act == hois_pkg::ACT_ADD || act == hois_pkg::ACT_REMOVE)
            && m <= MW'(MAX_ENTRIES)) begin
          bank  <= ~bank;
          count <= CW'(m);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      priority if (act == hois_pkg::ACT_NONE) begin
        covered <= 1'b0;
        status  <= hois_pkg::ST_DONE;
      end else if (l >= r) begin
        covered <= 1'b0;
        status  <= hois_pkg::ST_EMPTY;
      end else if (act == hois_pkg::ACT_QUERY) begin
        covered <= cov;
        status  <= hois_pkg::ST_DONE;
      end else if (m > MW'(MAX_ENTRIES)) begin
        covered <= 1'b0;
        status  <= hois_pkg::ST_FULL;
      end else begin
        covered <= 1'b0;
        status  <= hois_pkg::ST_DONE;
      end
    end
  end

  assign sts.skip       = (act == hois_pkg::ACT_NONE) || (l >= r);
  assign sts.count_zero = (count == '0);
  assign sts.last       = (idx + 1'b1 == count);
  assign sts.again      = again;
  assign sts.out_free   = !out_valid || out_ready;

endmodule
